/* rtl/region_table_first_fit_allocator_macros.svh */
// Assertion macros for the region table allocator.
`ifndef REGION_TABLE_FIRST_FIT_ALLOCATOR_MACROS_SVH
`define REGION_TABLE_FIRST_FIT_ALLOCATOR_MACROS_SVH
`ifndef SYNTH
`define RTA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define RTA_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define RTA_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define RTA_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

/* rtl/rtffa_pkg.sv */
package rtffa_pkg;
    localparam int SLOTS = 64;
    localparam int SLOT_W = $clog2(SLOTS);
    localparam int CNT_W = $clog2(SLOTS + 1);

    localparam logic [2:0] CMD_REQUEST = 3'd0;
    localparam logic [2:0] CMD_RELEASE = 3'd1;
    localparam logic [2:0] CMD_MAP = 3'd2;
    localparam logic [2:0] CMD_UNMAP = 3'd3;
    localparam logic [2:0] CMD_FIND_ADDR = 3'd4;
    localparam logic [2:0] CMD_FIND_KIND = 3'd5;
    localparam logic [2:0] CMD_READ = 3'd6;
    localparam logic [2:0] CMD_COUNT = 3'd7;

    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_INVALID = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [1:0] ST_FULL = 2'd3;

    localparam logic [3:0] K_EMPTY = 4'd0;
    localparam logic [3:0] K_FREE = 4'd1;
    localparam logic [3:0] K_RESERVED = 4'd2;
    localparam logic [3:0] K_LAST = 4'd12;

    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_SCAN, S_FETCH, S_WAIT, S_WRITE, S_DONE
    } state_t;
endpackage

/* rtl/region_table_first_fit_allocator.sv */
// A command that walks the table (request, map, both finds) shows its result after a scan of
// every slot; a request then has two write steps, since it can write two slots.
// Release, unmap and read slot read the named slot first, and count goes straight to its result;
// the block returns to idle as a result is loaded, and a waiting result stalls it.
// Reset (aresetn, synchronous, active low) starts a clearing pass that empties
// the table; no transfer is accepted until it is done.
`include "region_table_first_fit_allocator_macros.svh"
module region_table_first_fit_allocator (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // cmd[2:0], req_size[34:3], region_base[66:35], region_kind[70:67], slot[76:71]
    input  logic [79:0]  s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // status[1:0], hit_slot[7:2], hit_base[39:8], hit_size[71:40], hit_kind[75:72],
    // live_slots[82:76]
    output logic [87:0]  m_tdata
);
    import rtffa_pkg::*;

    logic [67:0] mem [SLOTS];
    logic [67:0] rd_q;
    logic        we;
    logic [SLOT_W-1:0] waddr, raddr;
    logic [67:0] wdata;

    always_ff @(posedge aclk) begin
        if (we) mem[waddr] <= wdata;
        rd_q <= mem[raddr];
    end

    state_t state_reg, state_next;
    logic [2:0]  cmd_reg;
    logic [31:0] size_reg, base_reg;
    logic [3:0]  kind_reg;
    logic [SLOT_W-1:0] slot_reg;
    logic [CNT_W:0] idx_reg, idx_next;      // scan address, can reach SLOTS
    logic        rd_v_reg;
    logic [SLOT_W-1:0] rd_i_reg;
    logic        fit_v_reg, emp_v_reg, hit_v_reg;
    logic [SLOT_W-1:0] fit_i_reg, emp_i_reg, hit_i_reg;
    logic [31:0] fit_base_reg, fit_size_reg;
    logic [CNT_W-1:0] live_reg;
    logic        wstep_reg;
    logic [1:0]  st_reg;
    logic [SLOT_W-1:0] os_reg;
    logic [67:0] oe_reg;
    logic        ov_reg;
    logic [87:0] m_reg;

    wire [2:0]  in_cmd  = s_tdata[2:0];
    wire [31:0] rd_base = rd_q[31:0];
    wire [31:0] rd_size = rd_q[63:32];
    wire [3:0]  rd_kind = rd_q[67:64];
    wire        s_fire  = s_tvalid && s_tready;
    wire        out_free = !ov_reg || m_tready;
    wire        scanning = (state_reg == S_SCAN);
    wire        scan_end = scanning && !rd_v_reg && idx_reg >= (CNT_W+1)'(SLOTS);
    wire        need_fit = (cmd_reg == CMD_REQUEST);
    wire        need_emp = (cmd_reg == CMD_REQUEST) || (cmd_reg == CMD_MAP);

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = ov_reg;
    assign m_tdata  = m_reg;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR: if (idx_reg == (CNT_W+1)'(SLOTS - 1)) state_next = S_IDLE;
            S_IDLE:  if (s_fire) begin
                unique case (in_cmd)
                    CMD_RELEASE, CMD_UNMAP, CMD_READ: state_next = S_FETCH;
                    CMD_COUNT: state_next = S_DONE;
                    default: state_next = S_SCAN;
                endcase
            end
            S_SCAN:  if (scan_end) state_next = S_WRITE;
            S_FETCH: state_next = S_WAIT;
            S_WAIT:  state_next = S_WRITE;
            S_WRITE: state_next = (cmd_reg == CMD_REQUEST && !wstep_reg) ? S_WRITE : S_DONE;
            S_DONE:  if (out_free) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        idx_next = idx_reg;
        if (state_reg == S_CLEAR) idx_next = idx_reg + 1'b1;
        else if (s_fire) idx_next = '0;
        else if (scanning && idx_reg < (CNT_W+1)'(SLOTS)) idx_next = idx_reg + 1'b1;
    end

    // Memory port control: clear sweep, scan reads, slot reads, write-backs.
    always_comb begin
        we = 1'b0;
        waddr = '0;
        wdata = '0;
        raddr = idx_reg[SLOT_W-1:0];
        if (state_reg == S_CLEAR) begin
            we = 1'b1;
            waddr = idx_reg[SLOT_W-1:0];
        end else if (state_reg == S_FETCH || state_reg == S_WAIT) begin
            // The slot is read twice so its data is still on hand in the write cycle.
            raddr = slot_reg;
        end else if (state_reg == S_WRITE) begin
            case (cmd_reg)
                CMD_REQUEST: begin
                    if (fit_v_reg && emp_v_reg && size_reg != '0) begin
                        we = 1'b1;
                        if (!wstep_reg) begin
                            waddr = emp_i_reg;
                            wdata = {K_RESERVED, size_reg, fit_base_reg};
                        end else begin
                            waddr = fit_i_reg;
                            wdata = {K_FREE, fit_size_reg - size_reg,
                                     fit_base_reg + size_reg};
                        end
                    end
                end
                CMD_MAP: begin
                    if (st_reg == ST_OK) begin
                        we = 1'b1;
                        waddr = emp_i_reg;
                        wdata = {kind_reg, size_reg, base_reg};
                    end
                end
                CMD_RELEASE: begin
                    if (rd_kind != K_EMPTY) begin
                        we = 1'b1;
                        waddr = slot_reg;
                        wdata = {K_FREE, rd_size, rd_base};
                    end
                end
                CMD_UNMAP: begin
                    we = 1'b1;
                    waddr = slot_reg;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
            idx_reg <= '0;
            rd_v_reg <= 1'b0;
            live_reg <= '0;
            ov_reg <= 1'b0;
            wstep_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            idx_reg <= idx_next;
            rd_v_reg <= scanning && idx_reg < (CNT_W+1)'(SLOTS);
            rd_i_reg <= idx_reg[SLOT_W-1:0];
            if (ov_reg && m_tready) ov_reg <= 1'b0;
            if (s_fire) begin
                cmd_reg <= in_cmd;
                size_reg <= s_tdata[34:3];
                base_reg <= s_tdata[66:35];
                kind_reg <= s_tdata[70:67];
                slot_reg <= s_tdata[76:71];
                fit_v_reg <= 1'b0;
                emp_v_reg <= 1'b0;
                hit_v_reg <= 1'b0;
                wstep_reg <= 1'b0;
            end
            if (scanning && rd_v_reg) begin
                if (need_fit && !fit_v_reg && rd_kind == K_FREE && rd_size >= size_reg) begin
                    fit_v_reg <= 1'b1;
                    fit_i_reg <= rd_i_reg;
                    fit_base_reg <= rd_base;
                    fit_size_reg <= rd_size;
                end
                if (need_emp && !emp_v_reg && rd_kind == K_EMPTY) begin
                    emp_v_reg <= 1'b1;
                    emp_i_reg <= rd_i_reg;
                end
                if (!hit_v_reg && ((cmd_reg == CMD_FIND_ADDR && rd_kind != K_EMPTY
                        && rd_base == base_reg) ||
                        (cmd_reg == CMD_FIND_KIND && rd_kind == kind_reg))) begin
                    hit_v_reg <= 1'b1;
                    hit_i_reg <= rd_i_reg;
                    oe_reg <= rd_q;
                end
            end
            // Decide status and result entry once the table data is known.
            if (scan_end || state_reg == S_WAIT) begin
                st_reg <= ST_OK;
                os_reg <= '0;
                oe_reg <= '0;
                case (cmd_reg)
                    CMD_REQUEST: begin
                        if (size_reg == '0) st_reg <= ST_INVALID;
                        else if (!fit_v_reg) st_reg <= ST_NOT_FOUND;
                        else if (!emp_v_reg) st_reg <= ST_FULL;
                        else begin
                            os_reg <= emp_i_reg;
                            oe_reg <= {K_RESERVED, size_reg, fit_base_reg};
                            live_reg <= live_reg + 1'b1;
                        end
                    end
                    CMD_MAP: begin
                        if (size_reg == '0 || kind_reg == K_EMPTY || kind_reg > K_LAST)
                            st_reg <= ST_INVALID;
                        else if (!emp_v_reg) st_reg <= ST_FULL;
                        else begin
                            os_reg <= emp_i_reg;
                            oe_reg <= {kind_reg, size_reg, base_reg};
                            live_reg <= live_reg + 1'b1;
                        end
                    end
                    CMD_FIND_ADDR, CMD_FIND_KIND: begin
                        if (!hit_v_reg) st_reg <= ST_NOT_FOUND;
                        else begin
                            os_reg <= hit_i_reg;
                            oe_reg <= oe_reg;
                        end
                    end
                    CMD_RELEASE: begin
                        if (rd_kind == K_EMPTY) st_reg <= ST_NOT_FOUND;
                        else begin
                            os_reg <= slot_reg;
                            oe_reg <= {K_FREE, rd_size, rd_base};
                        end
                    end
                    CMD_UNMAP: begin
                        os_reg <= slot_reg;
                        if (rd_kind != K_EMPTY && live_reg != '0) live_reg <= live_reg - 1'b1;
                    end
                    default: begin
                        os_reg <= slot_reg;
                        oe_reg <= rd_q;
                    end
                endcase
            end
            if (state_reg == S_WRITE) wstep_reg <= (cmd_reg == CMD_REQUEST) && !wstep_reg;
            if (state_reg == S_DONE && out_free) begin
                ov_reg <= 1'b1;
                if (cmd_reg == CMD_COUNT)
                    m_reg <= {5'd0, live_reg, 76'd0};
                else
                    m_reg <= {5'd0, live_reg, oe_reg, os_reg, st_reg};
            end
        end
    end

    `RTA_ASSERT_IMP(a_no_accept_busy, aclk, aresetn, state_reg != S_IDLE, !s_tready)
    `RTA_ASSERT_IMP(a_no_write_idle, aclk, aresetn, state_reg == S_IDLE, !we)
    `RTA_ASSERT_NXT(a_done_gives_out, aclk, aresetn, state_reg == S_DONE, m_tvalid)
    `RTA_ASSERT_IMP(a_live_bound, aclk, aresetn, 1'b1, live_reg <= CNT_W'(SLOTS))
endmodule
